FILE: design/pct_pkg.sv
`default_nettype none
package pct_pkg;

    localparam int SLOTS_DEFAULT = 8;

    localparam int ID_W      = 16;
    localparam int KIND_W    = 2;
    localparam int TIME_W    = 32;
    localparam int ACTION_W  = 2;
    localparam int OUTCOME_W = 3;

    localparam int NUM_KINDS = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = TIME_W;

    // Slot memory word: id in the low bits, then kind, then deadline.
    localparam int SLOT_W = ID_W + KIND_W + TIME_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

    localparam logic [TIME_W-1:0] TIMEOUT_RESET [NUM_KINDS] = '{
        TIME_W'(5000), TIME_W'(5000), TIME_W'(2000), TIME_W'(30000)
    };

    typedef enum logic [ACTION_W-1:0] {
        ACT_ISSUE    = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_CHECK    = 2'd2
    } action_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ISSUED     = 3'd0,
        OUT_DROPPED    = 3'd1,
        OUT_COMPLETED  = 3'd2,
        OUT_NO_MATCH   = 3'd3,
        OUT_TIMED_OUT  = 3'd4,
        OUT_CHECK_DONE = 3'd5
    } outcome_t;

    typedef struct packed {
        logic     load;
        logic     idx_inc;
        logic     write_slot;
        logic     clear_valid;
        logic     emit;
        outcome_t emit_code;
    } pct_cmd_t;

    typedef struct packed {
        logic in_done_zero;
        logic slot_free;
        logic match;
        logic expired;
        logic idx_last;
        logic out_free;
    } pct_status_t;

endpackage
`default_nettype wire

FILE: design/pct_ram.sv
`default_nettype none
module pct_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: design/pct_datapath.sv
`default_nettype none
module pct_datapath #(
    parameter int SLOTS = pct_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [pct_pkg::ACTION_W-1:0]    in_action,
    input  wire logic [pct_pkg::KIND_W-1:0]      in_kind,
    input  wire logic [pct_pkg::ID_W-1:0]        in_done_id,
    input  wire logic [pct_pkg::TIME_W-1:0]      in_now,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire pct_pkg::pct_cmd_t               cmd,
    output pct_pkg::pct_status_t                 status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pct_pkg::OUTCOME_W-1:0]        out_outcome,
    output logic [pct_pkg::ID_W-1:0]             out_id,
    output logic [pct_pkg::KIND_W-1:0]           out_kind,
    output logic                                 out_last
);
    import pct_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    logic [TIME_W-1:0] timeout_reg [NUM_KINDS];
    logic [SLOTS-1:0]  valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [ID_W-1:0]   next_id_reg;

    logic [KIND_W-1:0] item_kind_reg;
    logic [ID_W-1:0]   item_done_id_reg;
    logic [TIME_W-1:0] item_now_reg;
    logic [ID_W-1:0]   item_id_reg;

    logic                 out_valid_reg;
    logic [OUTCOME_W-1:0] out_outcome_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_last_reg;

    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    logic [ID_W-1:0]   rd_id;
    logic [KIND_W-1:0] rd_kind;
    logic [TIME_W-1:0] rd_deadline;
    logic [TIME_W-1:0] deadline;
    logic              out_free;

    logic [OUTCOME_W-1:0] emit_outcome_next;
    logic [ID_W-1:0]      emit_id_next;
    logic [KIND_W-1:0]    emit_kind_next;

    assign deadline  = item_now_reg + timeout_reg[item_kind_reg];
    assign ram_wdata = {deadline, item_kind_reg, item_id_reg};

    pct_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS),
        .ADDR_W(IDX_W)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (cmd.write_slot),
        .waddr(idx_reg),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_id       = ram_rdata[ID_W-1:0];
    assign rd_kind     = ram_rdata[ID_W +: KIND_W];
    assign rd_deadline = ram_rdata[ID_W+KIND_W +: TIME_W];

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        status.in_done_zero = (in_done_id == '0);
        status.slot_free    = !valid_reg[idx_reg];
        status.match        = valid_reg[idx_reg] && (rd_id == item_done_id_reg);
        status.expired      = valid_reg[idx_reg] && (rd_deadline != '0)
                              && !(item_now_reg < rd_deadline);
        status.idx_last     = (idx_reg == IDX_LAST);
        status.out_free     = out_free;
    end

    always_comb begin
        emit_outcome_next = cmd.emit_code;
        emit_id_next      = '0;
        emit_kind_next    = '0;
        unique case (cmd.emit_code)
            OUT_ISSUED, OUT_DROPPED: begin
                emit_id_next   = item_id_reg;
                emit_kind_next = item_kind_reg;
            end
            OUT_COMPLETED: begin
                emit_id_next = item_done_id_reg;
            end
            OUT_TIMED_OUT: begin
                emit_id_next   = rd_id;
                emit_kind_next = rd_kind;
            end
            default: begin
                emit_id_next   = '0;
                emit_kind_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
                timeout_reg[k] <= TIMEOUT_RESET[k];
            end
            valid_reg     <= '0;
            idx_reg       <= '0;
            next_id_reg   <= ID_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg[cfg_index] <= cfg_wdata;
            end

            if (cmd.load) begin
                idx_reg <= '0;
                if (in_action == ACT_ISSUE) begin
                    // The id counter never hands out zero.
                    next_id_reg <= (next_id_reg == '1) ? ID_FIRST : next_id_reg + ID_FIRST;
                end
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (cmd.write_slot) begin
                valid_reg[idx_reg] <= 1'b1;
            end else if (cmd.clear_valid) begin
                valid_reg[idx_reg] <= 1'b0;
            end

            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_kind_reg    <= in_kind;
            item_done_id_reg <= in_done_id;
            item_now_reg     <= in_now;
            item_id_reg      <= next_id_reg;
        end
        if (cmd.emit) begin
            out_outcome_reg <= emit_outcome_next;
            out_id_reg      <= emit_id_next;
            out_kind_reg    <= emit_kind_next;
            out_last_reg    <= (cmd.emit_code != OUT_TIMED_OUT);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_outcome = out_outcome_reg;
    assign out_id      = out_id_reg;
    assign out_kind    = out_kind_reg;
    assign out_last    = out_last_reg;

endmodule
`default_nettype wire

FILE: design/pct_ctrl.sv
`default_nettype none
module pct_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pct_pkg::ACTION_W-1:0]  in_action,
    input  wire pct_pkg::pct_status_t          status,
    output pct_pkg::pct_cmd_t                  cmd
);
    import pct_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FETCH,
        ST_TEST,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    outcome_t              code_reg, code_next;
    logic [ACTION_W-1:0]   act_reg, act_next;

    always_comb begin
        state_next    = state_reg;
        code_next     = code_reg;
        act_next      = act_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.emit_code = code_reg;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    act_next = in_action;
                    unique case (in_action)
                        ACT_ISSUE: begin
                            state_next = ST_ISSUE;
                        end
                        ACT_COMPLETE: begin
                            if (status.in_done_zero) begin
                                code_next  = OUT_NO_MATCH;
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_FETCH;
                            end
                        end
                        ACT_CHECK: begin
                            state_next = ST_FETCH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ISSUE: begin
                priority if (status.slot_free) begin
                    cmd.write_slot = 1'b1;
                    code_next      = OUT_ISSUED;
                    state_next     = ST_EMIT;
                end else if (status.idx_last) begin
                    code_next  = OUT_DROPPED;
                    state_next = ST_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end

            // The slot memory read is registered: its word is ready in the cycle after the index is set.
            ST_FETCH: begin
                state_next = ST_TEST;
            end

            ST_TEST: begin
                if (act_reg == ACT_COMPLETE) begin
                    priority if (status.match) begin
                        cmd.clear_valid = 1'b1;
                        code_next       = OUT_COMPLETED;
                        state_next      = ST_EMIT;
                    end else if (status.idx_last) begin
                        code_next  = OUT_NO_MATCH;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end else if (status.expired && !status.out_free) begin
                    // Hold here until the timed-out word can be sent.
                    state_next = ST_TEST;
                end else begin
                    if (status.expired) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_code   = OUT_TIMED_OUT;
                        cmd.clear_valid = 1'b1;
                    end
                    if (status.idx_last) begin
                        code_next  = OUT_CHECK_DONE;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end

            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            code_reg  <= OUT_ISSUED;
            act_reg   <= '0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            act_reg   <= act_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/pending_command_tracker_unit.sv
`default_nettype none
// Pending command tracker: keeps up to SLOTS outstanding commands, each with a
// 16-bit id, a kind and a deadline of now_ms plus the kind's timeout register.
// One word is taken at a time. An issue walks over the valid bits for the
// first free slot and then sends the result; a complete or a deadline check
// visits the single read port of the slot memory at most once per slot, with
// a fetch and a test state. A check sends one timed-out word per expired slot
// in slot order and then a done word with tlast set; every other action ends
// in a single word with tlast set. A stalled output adds cycles. Action code 3
// is swallowed with no result. Timeout registers may be written only while the
// block is idle.
module pending_command_tracker_unit #(
    parameter int SLOTS = pct_pkg::SLOTS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: command_kind[1:0], done_id[17:2], now_ms[49:18], zero pad.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pct_pkg::IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: action[1:0].
    input  wire logic [pct_pkg::ACTION_W-1:0]    s_tuser,
    // m_tdata: result_id[15:0], result_kind[17:16], zero pad.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pct_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser: outcome[2:0].
    output logic [pct_pkg::OUTCOME_W-1:0]        m_tuser,
    output logic                                 m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import pct_pkg::*;

    pct_cmd_t    cmd;
    pct_status_t status;
    logic        in_accept_ready;

    logic [KIND_W-1:0] in_kind;
    logic [ID_W-1:0]   in_done_id;
    logic [TIME_W-1:0] in_now;
    logic [ID_W-1:0]   out_id;
    logic [KIND_W-1:0] out_kind;

    assign in_kind    = s_tdata[KIND_W-1:0];
    assign in_done_id = s_tdata[KIND_W +: ID_W];
    assign in_now     = s_tdata[KIND_W+ID_W +: TIME_W];

    pct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (in_accept_ready),
        .in_action(s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    pct_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_action  (s_tuser),
        .in_kind    (in_kind),
        .in_done_id (in_done_id),
        .in_now     (in_now),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_outcome(m_tuser),
        .out_id     (out_id),
        .out_kind   (out_kind),
        .out_last   (m_tlast)
    );

    assign s_tready = in_accept_ready;
    assign m_tdata  = {(OUT_TDATA_W - ID_W - KIND_W)'(0), out_kind, out_id};

endmodule
`default_nettype wire
